### design/text_terminal_cell_writer_assert.svh
// ----------------------------------------------------------------------------
// text terminal cell writer assertion macros
// shared forms for the concurrent checks on the block ports
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CELL_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_CELL_WRITER_ASSERT_SVH

// same-cycle implication, off while reset is high
`define TTCW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ttcw assertion failed");

// next-cycle implication, off while reset is high
`define TTCW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttcw assertion failed");

`endif

### design/ttcw_pkg.sv
// ----------------------------------------------------------------------------
// ttcw_pkg
// types and constants shared by the text terminal cell writer
// ----------------------------------------------------------------------------
package ttcw_pkg;

   localparam int SCREEN_COLUMNS_DEFAULT = 80;
   localparam int SCREEN_ROWS_DEFAULT    = 25;

   localparam int CHAR_W  = 8;
   localparam int COLOUR_W = 8;
   localparam int ADDR_W  = 11;
   localparam int CELL_W  = 16;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int CNT_W   = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

   localparam int TAB_SPACES = 5;
   localparam logic [CNT_W-1:0] TAB_CELLS = CNT_W'(TAB_SPACES + 1);

   localparam logic [COLOUR_W-1:0] COLOUR_RESET = 8'd31;

   // register index as seen on paddr[2]
   localparam logic CSR_CELL_COLOUR = 1'b0;

   // one accepted character, ready to be spread into cell words
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [CHAR_W-1:0] char_code;
      logic [CNT_W-1:0]  count;
   } job_type;

endpackage

### design/ttcw_cursor.sv
// ----------------------------------------------------------------------------
// ttcw_cursor
// cursor tracking: line wrap, row advance and cell count per character
// ----------------------------------------------------------------------------
module ttcw_cursor #(
   parameter int SCREEN_COLUMNS = ttcw_pkg::SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = ttcw_pkg::SCREEN_ROWS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [ttcw_pkg::CHAR_W-1:0] char_code,
   output ttcw_pkg::job_type           job
);
   import ttcw_pkg::*;

   localparam int LIMIT  = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int FULL_W = $clog2(LIMIT + 8);

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [FULL_W-1:0] base_ff, base_in;   // row_ff * SCREEN_COLUMNS

   logic              is_nl, is_tab, wrap, row_last;
   logic [COL_W-1:0]  col_use;
   logic [FULL_W-1:0] addr_full, room;
   logic [CNT_W-1:0]  want;

   always_comb begin
      is_nl    = (char_code == CHAR_NEWLINE);
      is_tab   = (char_code == CHAR_TAB);
      wrap     = is_nl || (col_ff >= COL_W'(SCREEN_COLUMNS));
      row_last = (row_ff >= ROW_W'(SCREEN_ROWS - 1));

      if (wrap) begin
         row_in  = row_last ? '0 : row_ff + ROW_W'(1);
         base_in = row_last ? '0 : base_ff + FULL_W'(SCREEN_COLUMNS);
         col_use = '0;
      end else begin
         row_in  = row_ff;
         base_in = base_ff;
         col_use = col_ff;
      end

      if (is_nl)       want = '0;
      else if (is_tab) want = TAB_CELLS;
      else             want = CNT_W'(1);

      // cursor is always on screen here, so room is at least one
      addr_full = base_in + FULL_W'(col_use);
      room      = FULL_W'(LIMIT) - addr_full;
      col_in    = col_use + COL_W'(want);

      job.addr      = ADDR_W'(addr_full);
      job.char_code = char_code;
      job.count     = (room < FULL_W'(want)) ? CNT_W'(room) : want;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         base_ff <= '0;
      end else if (take) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         base_ff <= base_in;
      end
   end

endmodule

### design/text_terminal_cell_writer.sv
// ----------------------------------------------------------------------------
// text_terminal_cell_writer
// turns a character stream into 16-bit cell writes for a text screen
// ----------------------------------------------------------------------------
// usage
//   req channel: one character word per handshake (req_valid high, req_stall
//   low). rsp channel: one cell write word per handshake, with the linear
//   address, the cell (colour byte over character byte) and last_write on
//   the final word of a character. a newline yields no word; a tab yields
//   five spaces and then the tab code; cells beyond the screen end are
//   dropped while the cursor still moves.
//   an accepted character passes the job register, then the output register.
//   plain text flows at one character a cycle while rsp is not stalled; a tab
//   holds the input until its last word, since the single output register
//   drains one word a cycle from the job register unless rsp stalls.
//   a stalled rsp word holds, and the input stalls once the job register
//   cannot hand its last word over in that cycle.
//   reset clears the cursor to row 0, column 0, empties both stages and sets
//   the colour register to 31. the user writes the colour register over the
//   apb port at byte address 0 only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module text_terminal_cell_writer #(
   parameter int SCREEN_COLUMNS = ttcw_pkg::SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = ttcw_pkg::SCREEN_ROWS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // character input
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ttcw_pkg::CHAR_W-1:0]     req_char_code,
   // cell write output
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ttcw_pkg::ADDR_W-1:0]     rsp_write_address,
   output logic [ttcw_pkg::CELL_W-1:0]     rsp_cell_value,
   output logic                            rsp_last_write,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ttcw_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ttcw_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ttcw_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import ttcw_pkg::*;

   // colour register
   logic [COLOUR_W-1:0] colour_ff;

   // job register: the character whose words are being sent
   logic                job_valid_ff, job_valid_in;
   logic [ADDR_W-1:0]   job_addr_ff, job_addr_in;
   logic [CHAR_W-1:0]   job_char_ff, job_char_in;
   logic                job_tab_ff, job_tab_in;
   logic [CNT_W-1:0]    job_left_ff, job_left_in;
   logic [COLOUR_W-1:0] job_colour_ff, job_colour_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [CELL_W-1:0]   rsp_cell_ff, rsp_cell_in;
   logic                rsp_last_ff, rsp_last_in;

   logic    out_free, emit, job_done, take, csr_write;
   job_type new_job;

   ttcw_cursor #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_cursor (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_code (req_char_code),
      .job       (new_job)
   );

   // handshake control
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit      = job_valid_ff && out_free;
      job_done  = emit && (job_left_ff == CNT_W'(1));
      req_stall = job_valid_ff && !job_done;
      take      = req_valid && !req_stall;
   end

   // job register next state
   always_comb begin
      job_valid_in  = job_valid_ff;
      job_addr_in   = job_addr_ff;
      job_char_in   = job_char_ff;
      job_tab_in    = job_tab_ff;
      job_left_in   = job_left_ff;
      job_colour_in = job_colour_ff;
      if (take) begin
         // a newline leaves a zero count and loads no valid job
         job_valid_in  = (new_job.count != '0);
         job_addr_in   = new_job.addr;
         // a tab cut short by the screen end keeps only its spaces
         if ((new_job.char_code == CHAR_TAB) && (new_job.count != TAB_CELLS)) begin
            job_char_in = CHAR_SPACE;
         end else begin
            job_char_in = new_job.char_code;
         end
         job_tab_in    = (new_job.char_code == CHAR_TAB);
         job_left_in   = new_job.count;
         job_colour_in = colour_ff;
      end else if (job_done) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         job_addr_in = job_addr_ff + ADDR_W'(1);
         job_left_in = job_left_ff - CNT_W'(1);
      end
   end

   // output register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = job_addr_ff;
         // tab padding spaces come first, the tab code goes last
         if (job_tab_ff && (job_left_ff != CNT_W'(1))) begin
            rsp_cell_in = {job_colour_ff, CHAR_SPACE};
         end else begin
            rsp_cell_in = {job_colour_ff, job_char_ff};
         end
         rsp_last_in = (job_left_ff == CNT_W'(1));
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      job_addr_ff   <= job_addr_in;
      job_char_ff   <= job_char_in;
      job_tab_ff    <= job_tab_in;
      job_left_ff   <= job_left_in;
      job_colour_ff <= job_colour_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // register port: single colour register, no wait states
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff <= COLOUR_RESET;
      end else if (csr_write && (paddr[2] == CSR_CELL_COLOUR)) begin
         colour_ff <= pwdata[COLOUR_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_CELL_COLOUR) begin
         prdata = CSR_DATA_W'(colour_ff);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_cell_value    = rsp_cell_ff;
   assign rsp_last_write    = rsp_last_ff;

endmodule

### design/ttcw_checker.sv
// ----------------------------------------------------------------------------
// ttcw_checker
// port-level checks for the text terminal cell writer, bound to the top
// ----------------------------------------------------------------------------
`include "text_terminal_cell_writer_assert.svh"

module ttcw_checker #(
   parameter int SCREEN_COLUMNS = ttcw_pkg::SCREEN_COLUMNS_DEFAULT,
   parameter int SCREEN_ROWS    = ttcw_pkg::SCREEN_ROWS_DEFAULT
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ttcw_pkg::ADDR_W-1:0] rsp_write_address,
   input logic [ttcw_pkg::CELL_W-1:0] rsp_cell_value,
   input logic                        rsp_last_write
);
   import ttcw_pkg::*;

   localparam int LIMIT = SCREEN_COLUMNS * SCREEN_ROWS;

   logic [ADDR_W:0] addr_ext;
   logic            moved_mid;

   assign addr_ext  = {1'b0, rsp_write_address};
   assign moved_mid = rsp_valid && !rsp_stall && !rsp_last_write;

   // stalled word holds
   `TTCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_write_address) && $stable(rsp_cell_value))

   // every write lands on the screen
   `TTCW_ASSERT_NOW(a_addr_range, clock, reset, rsp_valid,
      (LIMIT > (1 << ADDR_W)) || (addr_ext < (ADDR_W + 1)'(LIMIT)))

   // words of one character follow at once, on consecutive cells
   `TTCW_ASSERT_NEXT(a_burst_next, clock, reset, moved_mid,
      rsp_valid && (rsp_write_address == $past(rsp_write_address) + ADDR_W'(1)))

   // a character in flight blocks new input while its words are stuck
   `TTCW_ASSERT_NOW(a_busy_stall, clock, reset,
      rsp_valid && rsp_stall && !rsp_last_write, req_stall)

endmodule

bind text_terminal_cell_writer ttcw_checker #(
   .SCREEN_COLUMNS (SCREEN_COLUMNS),
   .SCREEN_ROWS    (SCREEN_ROWS)
) u_ttcw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_write_address (rsp_write_address),
   .rsp_cell_value    (rsp_cell_value),
   .rsp_last_write    (rsp_last_write)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the text terminal cell writer: a queue-fed driver
// sends character words, a clocked monitor predicts the cell writes of each
// accepted character and checks every result word field by field, and the
// colour register is rewritten over the apb port between traffic phases
// ----------------------------------------------------------------------------
module tb_top;
   import ttcw_pkg::*;

   localparam int SCREEN_COLUMNS = SCREEN_COLUMNS_DEFAULT;
   localparam int SCREEN_ROWS    = SCREEN_ROWS_DEFAULT;
   localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;
   // drain margin for a tab's words through the job and output registers
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   // cursor over the text screen
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } cursor_type;

   // one cell write as seen on the rsp channel
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [CELL_W-1:0] value;
      logic              last_write;
   } cell_write_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_char_code;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [ADDR_W-1:0]     rsp_write_address;
   logic [CELL_W-1:0]     rsp_cell_value;
   logic                  rsp_last_write;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // character words still to be driven, filled by the stimulus process
   logic [CHAR_W-1:0] pending_chars[$];
   // cell writes predicted but not yet seen on the rsp channel
   cell_write_type    cells_due[$];

   cursor_type        screen_cursor;   // cursor as the monitor predicts it
   cursor_type        plan_cursor;     // cursor as the stimulus plans it
   logic [COLOUR_W-1:0] colour_reg;
   logic              char_accepted;
   int                tx_idle_pct;
   int                rx_idle_pct;
   int                mismatches;
   int                quiet_cycles;
   int                queued;

   text_terminal_cell_writer #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_char_code     (req_char_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_address (rsp_write_address),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_last_write    (rsp_last_write),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #10 clock = ~clock;

   // cell writes caused by one character; the cursor is advanced in place
   function automatic int render_char(inout cursor_type cur,
                                      input logic [CHAR_W-1:0] ch,
                                      input logic [COLOUR_W-1:0] colour,
                                      output cell_write_type cells [TAB_SPACES+1]);
      int n;
      int linear;
      logic [CHAR_W-1:0] glyph;
      n = 0;
      foreach (cells[i]) cells[i] = '0;
      // a newline or an overfull line moves to the start of the next row
      if (cur.col >= SCREEN_COLUMNS || ch == CHAR_NEWLINE) begin
         cur.col = '0;
         if (cur.row >= SCREEN_ROWS - 1)
            cur.row = '0;
         else
            cur.row = cur.row + ROW_W'(1);
      end
      if (ch == CHAR_NEWLINE)
         return 0;
      // a tab puts five spaces ahead of its own code
      for (int k = 0; k <= TAB_SPACES; k++) begin
         if (ch == CHAR_TAB || k == TAB_SPACES) begin
            glyph  = (k < TAB_SPACES) ? CHAR_SPACE : ch;
            linear = int'(cur.row) * SCREEN_COLUMNS + int'(cur.col);
            // cells past the screen end are dropped, the cursor still moves
            if (linear < SCREEN_CELLS) begin
               cells[n] = '{address: ADDR_W'(linear), value: {colour, glyph},
                            last_write: 1'b0};
               n++;
            end
            cur.col = cur.col + COL_W'(1);
         end
      end
      if (n > 0)
         cells[n-1].last_write = 1'b1;
      return n;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s", $time, msg);
   endtask

   // queue one character word and keep the planning cursor in step
   task automatic add_char(input logic [CHAR_W-1:0] ch);
      cell_write_type scratch [TAB_SPACES+1];
      pending_chars.push_back(ch);
      void'(render_char(plan_cursor, ch, '0, scratch));
      queued++;
   endtask

   // one apb transfer: setup cycle, then access cycle (pready is always high)
   task automatic csr_access(input logic wr, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {CSR_CELL_COLOUR, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // write the colour register, then read it back
   task automatic set_colour(input logic [CSR_DATA_W-1:0] data);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, data, rd);
      colour_reg = data[COLOUR_W-1:0];
      csr_access(1'b0, '0, rd);
      if (rd !== CSR_DATA_W'(colour_reg))
         report_mismatch($sformatf("colour readback: expected %0h, got %0h",
                                   colour_reg, rd));
   endtask

   // wait until every queued character is taken and every cell write seen,
   // then give a trailing newline time to leave the pipeline
   task automatic settle();
      while (pending_chars.size() != 0 || req_valid || cells_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // random traffic built from console-like sequences
   task automatic gen_random(input int count);
      int start;
      int r;
      int target;
      start = queued;
      while (queued - start < count) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            // a line of text, mostly short, sometimes running past the edge
            repeat ((r % 4 == 0) ? $urandom_range(60, 85) : $urandom_range(0, 20))
               add_char(CHAR_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 4) != 0)
               add_char(CHAR_NEWLINE);
         end else if (r < 55) begin
            // tab runs with the odd character between
            repeat ($urandom_range(1, 8)) begin
               add_char(CHAR_TAB);
               if ($urandom_range(0, 2) == 0)
                  add_char(CHAR_W'($urandom_range(33, 126)));
            end
         end else if (r < 65) begin
            // walk down to the last row, then tab into the screen end
            do add_char(CHAR_NEWLINE); while (plan_cursor.row != SCREEN_ROWS - 1);
            target = $urandom_range(SCREEN_COLUMNS - 10, SCREEN_COLUMNS);
            while (int'(plan_cursor.col) + TAB_SPACES + 1 <= target)
               add_char(CHAR_TAB);
            while (int'(plan_cursor.col) < target)
               add_char(CHAR_W'($urandom_range(33, 126)));
            add_char(CHAR_TAB);
            add_char(CHAR_W'($urandom_range(0, 255)));
         end else if (r < 72) begin
            // a full line with no newline, so the wrap comes from the width
            repeat (SCREEN_COLUMNS + $urandom_range(0, 2))
               add_char(CHAR_W'($urandom_range(11, 255)));
         end else begin
            // noise heavy in control codes
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(0, 3))
                  0: add_char(CHAR_TAB);
                  1: add_char(CHAR_NEWLINE);
                  default: add_char(CHAR_W'($urandom_range(0, 255)));
               endcase
            end
         end
      end
   endtask

   // driver: new character word and receiver stall on each falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || char_accepted) begin
         // the held word went through; offer the next one or idle
         if (pending_chars.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
            req_valid     <= 1'b1;
            req_char_code <= pending_chars.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predicts on each accepted character, checks each result word
   always @(posedge clock) begin : monitor
      int n;
      cell_write_type cells [TAB_SPACES+1];
      cell_write_type want;
      char_accepted <= req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            n = render_char(screen_cursor, req_char_code, colour_reg, cells);
            for (int i = 0; i < n; i++)
               cells_due.push_back(cells[i]);
         end
         if (rsp_valid && !rsp_stall) begin
            if (cells_due.size() == 0) begin
               report_mismatch($sformatf("unexpected cell write: addr %0d value %4h last %0b",
                                         rsp_write_address, rsp_cell_value,
                                         rsp_last_write));
            end else begin
               want = cells_due.pop_front();
               if (rsp_write_address !== want.address)
                  report_mismatch($sformatf("write_address: expected %0d, got %0d",
                                            want.address, rsp_write_address));
               if (rsp_cell_value !== want.value)
                  report_mismatch($sformatf("cell_value at %0d: expected %4h, got %4h",
                                            want.address, want.value, rsp_cell_value));
               if (rsp_last_write !== want.last_write)
                  report_mismatch($sformatf("last_write at %0d: expected %0b, got %0b",
                                            want.address, want.last_write,
                                            rsp_last_write));
            end
         end
      end
      // watchdog on cycles in which neither channel moves a word
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_char_code = '0;
      rsp_stall     = 1'b0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      char_accepted = 1'b0;
      screen_cursor = '0;
      plan_cursor   = '0;
      colour_reg    = COLOUR_RESET;
      mismatches    = 0;
      quiet_cycles  = 0;
      queued        = 0;
      tx_idle_pct   = 27;
      rx_idle_pct   = 53;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: byte extremes and alternating bits under the reset colour
      add_char(8'h00);
      add_char(8'hff);
      add_char(8'h55);
      add_char(8'haa);
      add_char(CHAR_SPACE);
      add_char(CHAR_TAB);
      // newline from mid line, then a newline on an empty line
      add_char(CHAR_NEWLINE);
      add_char(CHAR_NEWLINE);
      // thirteen tabs bring the cursor to column 78, the next tab spills over
      repeat (13) add_char(CHAR_TAB);
      add_char(CHAR_TAB);
      // the cursor is past the line end, so this one opens a new line
      add_char(CHAR_W'($urandom_range(33, 126)));
      settle();

      // colour at its low extreme, upper data bits random
      set_colour({CSR_DATA_W'($urandom) & ~CSR_DATA_W'(8'hff)});
      gen_random(95);
      settle();

      tx_idle_pct = 53;
      rx_idle_pct = 27;
      set_colour(CSR_DATA_W'(8'hff));
      gen_random(125);
      settle();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_colour(CSR_DATA_W'($urandom));
      gen_random(125);
      settle();

      if (cells_due.size() != 0)
         report_mismatch($sformatf("%0d cell writes never arrived", cells_due.size()));
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
